/* rtl/wrcp_pkg.sv */
// Shared types, constants and helpers for the WAV RIFF chunk parser.
package wrcp_pkg;

  localparam int unsigned MIN_FILE_BYTES = 44;
  localparam int unsigned HDR_LEN        = 12;
  localparam int unsigned FMT_KEEP       = 18;
  localparam int unsigned FMT_BASE_LEN   = 16;

  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] ID_DATA = 32'h6174_6164;  // "data"

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_BAD_HDR   = 3'd2;
  localparam logic [2:0] STAT_OVERRUN   = 3'd3;
  localparam logic [2:0] STAT_NOT_PCM   = 3'd4;
  localparam logic [2:0] STAT_FMT_SMALL = 3'd5;
  localparam logic [2:0] STAT_NO_FMT    = 3'd6;
  localparam logic [2:0] STAT_NO_DATA   = 3'd7;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } chunk_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic        audio_valid;
    logic [7:0]  audio_byte;
    logic        fmt_valid;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] ext_size;
    logic        done_res;
    logic [2:0]  status;
  } out_item_t;

  // Expected byte of the RIFF/WAVE file header; positions 4..7 are not checked.
  function automatic logic [7:0] hdr_tag(input logic [3:0] pos);
    logic [7:0] tag;
    case (pos)
      4'd0:    tag = 8'h52;  // R
      4'd1:    tag = 8'h49;  // I
      4'd2:    tag = 8'h46;  // F
      4'd3:    tag = 8'h46;  // F
      4'd8:    tag = 8'h57;  // W
      4'd9:    tag = 8'h41;  // A
      4'd10:   tag = 8'h56;  // V
      4'd11:   tag = 8'h45;  // E
      default: tag = 8'h00;
    endcase
    return tag;
  endfunction

endpackage

/* rtl/wrcp_core.sv */
// Parser state and per-byte next-state logic; produces one result per stepped byte.
module wrcp_core
  import wrcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int unsigned FmtIdxW = $clog2(FMT_KEEP);

  logic [5:0]  byte_count_r,   byte_count_nxt;
  logic [3:0]  header_pos_r,   header_pos_nxt;
  logic [2:0]  chunk_hdr_pos_r, chunk_hdr_pos_nxt;
  logic [31:0] chunk_id_r,     chunk_id_nxt;
  logic [31:0] chunk_len_r,    chunk_len_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;
  logic [FmtIdxW-1:0] payload_pos_r, payload_pos_nxt;
  chunk_kind_t chunk_kind_r,   chunk_kind_nxt;
  logic [7:0]  fmt_r   [FMT_KEEP];
  logic [7:0]  fmt_nxt [FMT_KEEP];
  logic        found_fmt_r,    found_fmt_nxt;
  logic        found_data_r,   found_data_nxt;
  logic [2:0]  error_code_r,   error_code_nxt;
  logic [15:0] channels_r,     channels_nxt;
  logic [31:0] rate_r,         rate_nxt;
  logic [31:0] brate_r,        brate_nxt;
  logic [15:0] align_r,        align_nxt;
  logic [15:0] bits_r,         bits_nxt;
  logic [15:0] ext_r,          ext_nxt;

  logic        finish;
  logic        av, fv;
  logic [7:0]  ab;
  logic [2:0]  status;
  logic [7:0]  b;

  assign b = item.in_byte;

  always_comb begin
    byte_count_nxt    = byte_count_r;
    header_pos_nxt    = header_pos_r;
    chunk_hdr_pos_nxt = chunk_hdr_pos_r;
    chunk_id_nxt      = chunk_id_r;
    chunk_len_nxt     = chunk_len_r;
    payload_left_nxt  = payload_left_r;
    payload_pos_nxt   = payload_pos_r;
    chunk_kind_nxt    = chunk_kind_r;
    fmt_nxt           = fmt_r;
    found_fmt_nxt     = found_fmt_r;
    found_data_nxt    = found_data_r;
    error_code_nxt    = error_code_r;
    channels_nxt      = channels_r;
    rate_nxt          = rate_r;
    brate_nxt         = brate_r;
    align_nxt         = align_r;
    bits_nxt          = bits_r;
    ext_nxt           = ext_r;
    finish            = 1'b0;
    av                = 1'b0;
    ab                = 8'h00;
    fv                = 1'b0;

    if (byte_count_r < 6'(MIN_FILE_BYTES)) begin
      byte_count_nxt = byte_count_r + 6'd1;
    end

    if (error_code_r == STAT_OK) begin
      if (header_pos_r < 4'(HDR_LEN)) begin
        if ((header_pos_r < 4'd4 || header_pos_r >= 4'd8) && b != hdr_tag(header_pos_r)) begin
          error_code_nxt = STAT_BAD_HDR;
        end
        header_pos_nxt = header_pos_r + 4'd1;
      end else if (payload_left_r != 32'd0) begin
        if (chunk_kind_r == KIND_DATA) begin
          av = 1'b1;
          ab = b;
        end else if (chunk_kind_r == KIND_FMT && payload_pos_r < FmtIdxW'(FMT_KEEP)) begin
          fmt_nxt[payload_pos_r] = b;
          payload_pos_nxt = payload_pos_r + FmtIdxW'(1);
        end
        payload_left_nxt = payload_left_r - 32'd1;
        finish = (payload_left_r == 32'd1);
      end else begin
        if (chunk_hdr_pos_r < 3'd4) begin
          chunk_id_nxt = {b, chunk_id_r[31:8]};
        end else begin
          chunk_len_nxt = {b, chunk_len_r[31:8]};
        end
        if (chunk_hdr_pos_r == 3'd7) begin
          chunk_hdr_pos_nxt = 3'd0;
          if (chunk_id_r == ID_FMT) begin
            chunk_kind_nxt = KIND_FMT;
          end else if (chunk_id_r == ID_DATA) begin
            chunk_kind_nxt = KIND_DATA;
            found_data_nxt = 1'b1;
          end else begin
            chunk_kind_nxt = KIND_OTHER;
          end
          payload_left_nxt = chunk_len_nxt;
          payload_pos_nxt  = '0;
          for (int i = 0; i < FMT_KEEP; i++) begin
            fmt_nxt[i] = 8'h00;
          end
          finish = (chunk_len_nxt == 32'd0);
        end else begin
          chunk_hdr_pos_nxt = chunk_hdr_pos_r + 3'd1;
        end
      end
    end

    // Close the chunk: validate and latch a PCM fmt chunk
    if (finish) begin
      if (chunk_kind_nxt == KIND_FMT) begin
        if (chunk_len_nxt < 32'd2) begin
          error_code_nxt = STAT_FMT_SMALL;
        end else if ({fmt_nxt[1], fmt_nxt[0]} != 16'd1) begin
          error_code_nxt = STAT_NOT_PCM;
        end else if (chunk_len_nxt != 32'(FMT_BASE_LEN) && chunk_len_nxt < 32'(FMT_KEEP)) begin
          error_code_nxt = STAT_FMT_SMALL;
        end else begin
          channels_nxt  = {fmt_nxt[3], fmt_nxt[2]};
          rate_nxt      = {fmt_nxt[7], fmt_nxt[6], fmt_nxt[5], fmt_nxt[4]};
          brate_nxt     = {fmt_nxt[11], fmt_nxt[10], fmt_nxt[9], fmt_nxt[8]};
          align_nxt     = {fmt_nxt[13], fmt_nxt[12]};
          bits_nxt      = {fmt_nxt[15], fmt_nxt[14]};
          ext_nxt       = (chunk_len_nxt == 32'(FMT_BASE_LEN)) ? 16'd0 :
                          {fmt_nxt[17], fmt_nxt[16]};
          found_fmt_nxt = 1'b1;
          fv            = 1'b1;
        end
      end
      chunk_kind_nxt = KIND_OTHER;
    end

    status = error_code_nxt;
    if (item.is_last) begin
      if (byte_count_nxt < 6'(MIN_FILE_BYTES)) begin
        status = STAT_SHORT;
      end else if (error_code_nxt != STAT_OK) begin
        status = error_code_nxt;
      end else if (header_pos_nxt < 4'(HDR_LEN)) begin
        status = STAT_BAD_HDR;
      end else if (payload_left_nxt != 32'd0) begin
        status = STAT_OVERRUN;
      end else if (!found_fmt_nxt) begin
        status = STAT_NO_FMT;
      end else if (!found_data_nxt) begin
        status = STAT_NO_DATA;
      end else begin
        status = STAT_OK;
      end
    end
  end

  always_comb begin
    result.audio_valid     = av;
    result.audio_byte      = ab;
    result.fmt_valid       = fv;
    result.channels        = channels_nxt;
    result.sample_rate     = rate_nxt;
    result.byte_rate       = brate_nxt;
    result.block_align     = align_nxt;
    result.bits_per_sample = bits_nxt;
    result.ext_size        = ext_nxt;
    result.done_res        = item.is_last;
    result.status          = status;
  end

  // The last byte of a file returns everything to reset for the next file
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      byte_count_r    <= '0;
      header_pos_r    <= '0;
      chunk_hdr_pos_r <= '0;
      chunk_id_r      <= '0;
      chunk_len_r     <= '0;
      payload_left_r  <= '0;
      payload_pos_r   <= '0;
      chunk_kind_r    <= KIND_OTHER;
      for (int i = 0; i < FMT_KEEP; i++) begin
        fmt_r[i] <= 8'h00;
      end
      found_fmt_r     <= 1'b0;
      found_data_r    <= 1'b0;
      error_code_r    <= STAT_OK;
      channels_r      <= '0;
      rate_r          <= '0;
      brate_r         <= '0;
      align_r         <= '0;
      bits_r          <= '0;
      ext_r           <= '0;
    end else if (step) begin
      byte_count_r    <= byte_count_nxt;
      header_pos_r    <= header_pos_nxt;
      chunk_hdr_pos_r <= chunk_hdr_pos_nxt;
      chunk_id_r      <= chunk_id_nxt;
      chunk_len_r     <= chunk_len_nxt;
      payload_left_r  <= payload_left_nxt;
      payload_pos_r   <= payload_pos_nxt;
      chunk_kind_r    <= chunk_kind_nxt;
      fmt_r           <= fmt_nxt;
      found_fmt_r     <= found_fmt_nxt;
      found_data_r    <= found_data_nxt;
      error_code_r    <= error_code_nxt;
      channels_r      <= channels_nxt;
      rate_r          <= rate_nxt;
      brate_r         <= brate_nxt;
      align_r         <= align_nxt;
      bits_r          <= bits_nxt;
      ext_r           <= ext_nxt;
    end
  end

endmodule

/* rtl/wav_riff_chunk_parser.sv */
// Top level of the WAV RIFF chunk parser: handshake and result register.
//
// Feed a WAV file one byte per transaction on the in_ channel (in_valid,
// in_ready, in_data), with is_last set on the final byte. Every accepted byte
// yields exactly one result transaction on the out_ channel: the data chunk
// payload byte when there is one, a fmt_valid pulse when a PCM fmt chunk
// closes, the latched format fields, and on the last byte the file status.
// The result is registered: it is loaded into the output register at the
// accepting edge. Throughput is one byte per cycle while out_ready stays
// high; the parse state updates at the same edge that accepts the byte.
// When the receiver stalls (out_ready low), the result holds and in_ready
// drops until it is taken; in_ready follows out_ready in the same cycle, so
// no bubble is added. Synchronous reset (rst_n low) clears the parse state
// and empties the output register. After a last byte the parse state
// returns to reset on its own, so the next file can follow at once.
module wav_riff_chunk_parser
  import wrcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      step;
  out_item_t result;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  wrcp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/wrcp_checker.sv */
// Port-level assertions for the WAV RIFF chunk parser, bound to the top level.
module wrcp_checker
  import wrcp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Every accepted byte shows a result on the next cycle
  a_one_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  // The result of an accepted byte carries that byte's last mark
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_data.done_res == $past(in_data.is_last))
    else $error("done_res does not follow the accepted byte");

  // A non-audio result carries a zero byte; the audio/fmt exclusion term sits under that same condition
  a_audio_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.audio_valid |-> out_data.audio_byte == 8'h00 &&
      !(out_data.audio_valid && out_data.fmt_valid))
    else $error("audio byte or fmt pulse inconsistent");

  // Final-only verdicts never appear mid-file
  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |->
      out_data.status != STAT_SHORT && out_data.status != STAT_OVERRUN &&
      out_data.status != STAT_NO_FMT && out_data.status != STAT_NO_DATA)
    else $error("final-only status shown before last byte");

endmodule

bind wav_riff_chunk_parser wrcp_checker u_wrcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/wav_riff_chunk_parser_test.sv */
// Self-checking testbench for the WAV RIFF chunk parser: random WAV files, predicted results.
module wav_riff_chunk_parser_test
  import wrcp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [95:0] FILE_TAG = {"RIFF", 32'h0, "WAVE"};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  wav_riff_chunk_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and scoreboard storage
  in_item_t    file_byte_feed[$];
  out_item_t   parse_results_due[$];
  logic [7:0]  file_bytes[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  logic        in_taken = 1'b0;
  out_item_t   predicted;

  // Parser state mirror
  int unsigned seen_bytes;
  int unsigned tag_pos;
  int unsigned hdr_idx;
  int unsigned fmt_fill;
  logic [31:0] chunk_tag;
  logic [31:0] chunk_size;
  logic [31:0] bytes_left;
  chunk_kind_t cur_kind;
  logic [7:0]  fmt_buf [FMT_KEEP];
  logic        saw_fmt;
  logic        saw_data;
  logic [2:0]  sticky_err;
  out_item_t   fmt_latch;

  task automatic clear_parser();
    seen_bytes = 0;
    tag_pos    = 0;
    hdr_idx    = 0;
    fmt_fill   = 0;
    chunk_tag  = '0;
    chunk_size = '0;
    bytes_left = '0;
    cur_kind   = KIND_OTHER;
    foreach (fmt_buf[i]) fmt_buf[i] = '0;
    saw_fmt    = 1'b0;
    saw_data   = 1'b0;
    sticky_err = STAT_OK;
    fmt_latch  = '0;
  endtask

  // Chunk payload complete: validate a fmt chunk and latch its fields
  task automatic close_chunk(output logic accepted);
    accepted = 1'b0;
    if (cur_kind == KIND_FMT) begin
      if (chunk_size < 2) begin
        sticky_err = STAT_FMT_SMALL;
      end else if ({fmt_buf[1], fmt_buf[0]} != 16'd1) begin
        sticky_err = STAT_NOT_PCM;
      end else if (chunk_size != FMT_BASE_LEN && chunk_size < FMT_KEEP) begin
        sticky_err = STAT_FMT_SMALL;
      end else begin
        fmt_latch.channels        = {fmt_buf[3], fmt_buf[2]};
        fmt_latch.sample_rate     = {fmt_buf[7], fmt_buf[6], fmt_buf[5], fmt_buf[4]};
        fmt_latch.byte_rate       = {fmt_buf[11], fmt_buf[10], fmt_buf[9], fmt_buf[8]};
        fmt_latch.block_align     = {fmt_buf[13], fmt_buf[12]};
        fmt_latch.bits_per_sample = {fmt_buf[15], fmt_buf[14]};
        fmt_latch.ext_size        = (chunk_size == FMT_BASE_LEN) ? 16'd0
                                                                 : {fmt_buf[17], fmt_buf[16]};
        saw_fmt  = 1'b1;
        accepted = 1'b1;
      end
    end
    cur_kind = KIND_OTHER;
  endtask

  task automatic parse_byte(input in_item_t item, output out_item_t res);
    logic [7:0] b;
    logic       fmt_done;
    b        = item.in_byte;
    res      = '0;
    fmt_done = 1'b0;
    if (seen_bytes < MIN_FILE_BYTES) seen_bytes++;
    if (sticky_err == STAT_OK) begin
      if (tag_pos < HDR_LEN) begin
        if ((tag_pos < 4 || tag_pos >= 8) && b != FILE_TAG[95 - 8 * tag_pos -: 8])
          sticky_err = STAT_BAD_HDR;
        tag_pos++;
      end else if (bytes_left != 0) begin
        if (cur_kind == KIND_DATA) begin
          res.audio_valid = 1'b1;
          res.audio_byte  = b;
        end else if (cur_kind == KIND_FMT && fmt_fill < FMT_KEEP) begin
          fmt_buf[fmt_fill] = b;
          fmt_fill++;
        end
        bytes_left--;
        if (bytes_left == 0) close_chunk(fmt_done);
      end else begin
        if (hdr_idx < 4) chunk_tag = {b, chunk_tag[31:8]};
        else chunk_size = {b, chunk_size[31:8]};
        if (hdr_idx == 7) begin
          hdr_idx  = 0;
          cur_kind = (chunk_tag == ID_FMT)  ? KIND_FMT :
                     (chunk_tag == ID_DATA) ? KIND_DATA : KIND_OTHER;
          if (cur_kind == KIND_DATA) saw_data = 1'b1;
          bytes_left = chunk_size;
          fmt_fill   = 0;
          foreach (fmt_buf[i]) fmt_buf[i] = '0;
          if (bytes_left == 0) close_chunk(fmt_done);
        end else begin
          hdr_idx++;
        end
      end
    end

    res.status = sticky_err;
    if (item.is_last) begin
      if (seen_bytes < MIN_FILE_BYTES) res.status = STAT_SHORT;
      else if (sticky_err != STAT_OK) res.status = sticky_err;
      else if (tag_pos < HDR_LEN) res.status = STAT_BAD_HDR;
      else if (bytes_left != 0) res.status = STAT_OVERRUN;
      else if (!saw_fmt) res.status = STAT_NO_FMT;
      else if (!saw_data) res.status = STAT_NO_DATA;
      else res.status = STAT_OK;
    end
    res.fmt_valid       = fmt_done;
    res.channels        = fmt_latch.channels;
    res.sample_rate     = fmt_latch.sample_rate;
    res.byte_rate       = fmt_latch.byte_rate;
    res.block_align     = fmt_latch.block_align;
    res.bits_per_sample = fmt_latch.bits_per_sample;
    res.ext_size        = fmt_latch.ext_size;
    res.done_res        = item.is_last;
    // the next file starts from a clean parser
    if (item.is_last) clear_parser();
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      clear_parser();
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (parse_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, actual %h", $time, out_data);
        end else begin
          predicted = parse_results_due.pop_front();
          compare_field("audio_valid", predicted.audio_valid, out_data.audio_valid);
          compare_field("audio_byte", predicted.audio_byte, out_data.audio_byte);
          compare_field("fmt_valid", predicted.fmt_valid, out_data.fmt_valid);
          compare_field("channels", predicted.channels, out_data.channels);
          compare_field("sample_rate", predicted.sample_rate, out_data.sample_rate);
          compare_field("byte_rate", predicted.byte_rate, out_data.byte_rate);
          compare_field("block_align", predicted.block_align, out_data.block_align);
          compare_field("bits_per_sample", predicted.bits_per_sample,
                        out_data.bits_per_sample);
          compare_field("ext_size", predicted.ext_size, out_data.ext_size);
          compare_field("done_res", predicted.done_res, out_data.done_res);
          compare_field("status", predicted.status, out_data.status);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_data, predicted);
        parse_results_due.insert(parse_results_due.size(), predicted);
        bytes_accepted++;
      end
    end
  end

  // Driver: hold until accepted, then idle in bursts or present the next byte
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the current transaction
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      send_gap <= $urandom_range(0, 3);
      in_valid <= 1'b0;
    end else if (file_byte_feed.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= file_byte_feed.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap  <= take_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      take_gap  <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // File builders
  task automatic add_byte(input logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endtask

  task automatic put_random(input int unsigned n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8 * i +: 8]);
  endtask

  task automatic put_header();
    for (int i = 0; i < 12; i++)
      add_byte((i >= 4 && i < 8) ? 8'($urandom_range(0, 255))
                                 : FILE_TAG[95 - 8 * i -: 8]);
  endtask

  task automatic put_fmt(input logic [31:0] len, input int unsigned body, input bit pcm);
    logic [15:0] fmt_tag;
    case ($urandom_range(0, 3))
      0:       fmt_tag = 16'd0;
      1:       fmt_tag = 16'd3;
      2:       fmt_tag = 16'h0101;
      default: fmt_tag = 16'($urandom_range(2, 65535));
    endcase
    if (pcm) fmt_tag = 16'd1;
    put_word(ID_FMT);
    put_word(len);
    for (int i = 0; i < body; i++) begin
      if (i < 2) add_byte(fmt_tag[8 * i +: 8]);
      else add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_fmt_any();
    int unsigned len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = FMT_BASE_LEN;
      5, 6:          len = FMT_KEEP + $urandom_range(0, 6);
      7:             len = FMT_KEEP - 1;
      8:             len = $urandom_range(0, 1);
      default:       len = $urandom_range(2, 15);
    endcase
    put_fmt(len, len, $urandom_range(0, 6) != 0);
  endtask

  task automatic put_data(input logic [31:0] len, input int unsigned body);
    put_word(ID_DATA);
    put_word(len);
    put_random(body);
  endtask

  // Unknown chunk, sometimes with an id one bit away from fmt or data
  task automatic put_other();
    int unsigned len;
    logic [31:0] id;
    len = $urandom_range(0, 8);
    case ($urandom_range(0, 2))
      0:       id = $urandom();
      1:       id = ID_FMT ^ (32'd1 << $urandom_range(0, 31));
      default: id = ID_DATA ^ (32'd1 << $urandom_range(0, 31));
    endcase
    put_word(id);
    put_word(len);
    put_random(len);
  endtask

  task automatic build_wav_file();
    int unsigned mode;
    int unsigned ending;
    int unsigned idx;
    logic [31:0] long_len;
    file_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      put_random($urandom_range(1, 60));
    end else begin
      put_header();
      if (mode < 13) begin
        idx = $urandom_range(0, 7);
        if (idx >= 4) idx += 4;
        file_bytes[idx] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 3) == 0) put_other();
      if ($urandom_range(0, 9) != 0) put_fmt_any();
      if ($urandom_range(0, 4) == 0) put_other();
      if ($urandom_range(0, 9) != 0) begin
        idx = $urandom_range(0, 24);
        put_data(idx, idx);
      end
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0) put_fmt_any();
        else put_data(3, 3);
      end
      ending = $urandom_range(0, 99);
      if (ending < 15) begin
        put_random($urandom_range(1, 7));
      end else if (ending < 30) begin
        // declared payload runs past the end of the file
        long_len = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(16, 80))
                                               : ($urandom() | 32'h100);
        if ($urandom_range(0, 1) == 0) put_data(long_len, $urandom_range(0, 15));
        else put_fmt(long_len, $urandom_range(0, 15), 1'b1);
      end else if (ending < 40) begin
        idx = ($urandom_range(0, 3) == 0) ? MIN_FILE_BYTES - 1
                                          : $urandom_range(1, MIN_FILE_BYTES - 1);
        while (file_bytes.size() > idx) void'(file_bytes.pop_back());
      end
    end
  endtask

  task automatic queue_file();
    in_item_t item;
    foreach (file_bytes[i]) begin
      item.in_byte = file_bytes[i];
      item.is_last = (i == file_bytes.size() - 1);
      file_byte_feed.insert(file_byte_feed.size(), item);
      bytes_queued++;
    end
  endtask

  task automatic queue_random_files(input int unsigned target);
    while (bytes_queued < target) begin
      build_wav_file();
      queue_file();
    end
  endtask

  task automatic wait_drained();
    while (bytes_accepted < bytes_queued || parse_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    @(posedge clk);
    idle_pct = 15;
    // one-byte files at the byte extremes
    file_bytes = '{8'hFF};
    queue_file();
    file_bytes = '{8'h00};
    queue_file();
    // bad tag in a file too short to count: short wins
    file_bytes.delete();
    put_header();
    file_bytes[3] = "X";
    queue_file();
    // well-formed PCM file with an extended fmt chunk
    file_bytes.delete();
    put_header();
    for (int i = 4; i < 8; i++) file_bytes[i] = 8'hFF;
    put_word(ID_FMT);
    put_word(FMT_KEEP);
    add_byte(8'h01);
    add_byte(8'h00);
    put_random(14);
    add_byte(8'hFF);
    add_byte(8'hFF);
    put_data(4, 0);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    queue_file();
    wait_drained();

    @(posedge clk);
    idle_pct = 25;
    queue_random_files(600);
    wait_drained();

    @(posedge clk);
    idle_pct = 8;
    queue_random_files(1050);
    wait_drained();

    @(posedge clk);
    idle_pct = 0;
    queue_random_files(1300);
    wait_drained();

    repeat (4) @(negedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
